/* sv/htcb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htcb_pkg: shared types and constants for the alphabetic code builder
// Command and status codes, controller states, datapath ops, status struct.
// ----------------------------------------------------------------------------
package htcb_pkg;

	localparam int SYMBOLS_DEF      = 256;
	localparam int MAX_CODE_LEN_DEF = 64;
	localparam int FREQ_W           = 32;
	localparam int WEIGHT_W         = 40;
	localparam int DEPTH_W          = 8;
	localparam int CODE_W           = 64;
	localparam int LEN_W            = 7;
	localparam int SYM_W            = 8;
	localparam int WORK_W           = 256;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_ABSENT   = 2'd1;
	localparam logic [1:0] STS_OVERLONG = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_LD_RD, ST_LD_WR, ST_LD_END,
		ST_FP_INIT, ST_FI_RD, ST_FI_CHK, ST_FJ_RD, ST_FJ_CHK,
		ST_MG_A, ST_MG_B, ST_MS_RD, ST_MS_WR,
		ST_AS_INIT, ST_AS_RD, ST_AS_CHK, ST_AS_STRIP, ST_AS_PAD, ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLR, OP_ACCEPT, OP_RD_RSP, OP_LD_WR,
		OP_FP_INIT, OP_FI_CHK, OP_FJ_RD, OP_FJ_CHK,
		OP_MG_A, OP_MG_B, OP_MS_WR,
		OP_AS_INIT, OP_AS_CHK, OP_STRIP, OP_PAD, OP_DONE
	} dp_op_t;

	typedef struct packed {
		logic out_free;
		logic last;
		logic n_zero;
		logic n_one;
		logic i_end;
		logic j_end;
		logic occ;
		logic leaf;
		logic found;
		logic more;
		logic skip;
		logic first;
		logic strip_more;
	} dp_sts_t;

endpackage
`default_nettype wire

/* sv/htcb_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htcb_ctrl: sequencer for the alphabetic code builder
// Steps through clear, load, pair search, merge and code assignment.
// ----------------------------------------------------------------------------
module htcb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [1:0]        command,
	input  htcb_pkg::dp_sts_t sts,
	output htcb_pkg::dp_op_t  op,
	output logic              cmd_stall
);
	import htcb_pkg::*;

	state_t state_q, state_d;
	logic   take;

	assign take = cmd_valid && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (take) begin
					if (command == CMD_BUILD) state_d = ST_LD_RD;
					else if (command == CMD_READ) state_d = ST_RD;
				end
			end
			ST_RD:    state_d = ST_IDLE;
			ST_LD_RD: state_d = ST_LD_WR;
			ST_LD_WR: state_d = sts.last ? ST_LD_END : ST_LD_RD;
			ST_LD_END: begin
				if (sts.n_zero) state_d = ST_DONE;
				else if (sts.n_one) state_d = ST_AS_INIT;
				else state_d = ST_FP_INIT;
			end
			ST_FP_INIT: state_d = ST_FI_RD;
			ST_FI_RD: begin
				if (sts.i_end) state_d = sts.found ? ST_MG_A : ST_AS_INIT;
				else state_d = ST_FI_CHK;
			end
			ST_FI_CHK: state_d = sts.occ ? ST_FJ_RD : ST_FI_RD;
			ST_FJ_RD:  state_d = sts.j_end ? ST_FI_RD : ST_FJ_CHK;
			ST_FJ_CHK: state_d = (sts.occ && sts.leaf) ? ST_FI_RD : ST_FJ_RD;
			ST_MG_A:   state_d = ST_MG_B;
			ST_MG_B:   state_d = ST_MS_RD;
			ST_MS_RD:  state_d = ST_MS_WR;
			ST_MS_WR: begin
				if (sts.last) state_d = sts.more ? ST_FP_INIT : ST_AS_INIT;
				else state_d = ST_MS_RD;
			end
			ST_AS_INIT: state_d = ST_AS_RD;
			ST_AS_RD:   state_d = ST_AS_CHK;
			ST_AS_CHK: begin
				if (sts.skip) state_d = sts.last ? ST_DONE : ST_AS_RD;
				else state_d = sts.first ? ST_AS_PAD : ST_AS_STRIP;
			end
			ST_AS_STRIP: state_d = sts.strip_more ? ST_AS_STRIP : ST_AS_PAD;
			ST_AS_PAD:   state_d = sts.last ? ST_DONE : ST_AS_RD;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op        = OP_NOP;
		cmd_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: op = OP_CLR;
			ST_IDLE: begin
				cmd_stall = !sts.out_free;
				if (take) op = OP_ACCEPT;
			end
			ST_RD:       op = OP_RD_RSP;
			ST_LD_WR:    op = OP_LD_WR;
			ST_FP_INIT:  op = OP_FP_INIT;
			ST_FI_CHK:   op = OP_FI_CHK;
			ST_FJ_RD:    op = OP_FJ_RD;
			ST_FJ_CHK:   op = OP_FJ_CHK;
			ST_MG_A:     op = OP_MG_A;
			ST_MG_B:     op = OP_MG_B;
			ST_MS_WR:    op = OP_MS_WR;
			ST_AS_INIT:  op = OP_AS_INIT;
			ST_AS_CHK:   op = OP_AS_CHK;
			ST_AS_STRIP: op = OP_STRIP;
			ST_AS_PAD:   op = OP_PAD;
			ST_DONE:     op = OP_DONE;
			default:     op = OP_NOP;
		endcase
	end

endmodule
`default_nettype wire

/* sv/htcb_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htcb_dp: datapath of the alphabetic code builder
// Frequency, work list, per-symbol and code memories, counters, response reg.
// ----------------------------------------------------------------------------
module htcb_dp #(
	parameter int SYMBOLS      = htcb_pkg::SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = htcb_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  htcb_pkg::dp_op_t              op,
	input  logic [1:0]                    command,
	input  logic [htcb_pkg::SYM_W-1:0]    symbol,
	input  logic [htcb_pkg::FREQ_W-1:0]   frequency,
	input  logic                          rsp_stall,
	output htcb_pkg::dp_sts_t             sts,
	output logic                          rsp_valid,
	output logic [htcb_pkg::CODE_W-1:0]   code_bits,
	output logic [htcb_pkg::LEN_W-1:0]    code_length,
	output logic [1:0]                    status
);
	import htcb_pkg::*;

	localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int CW = SW + 1;
	localparam int XW = 11;
	localparam int LW = WEIGHT_W + 2;
	localparam int YW = SW + DEPTH_W + 1;

	// memories
	logic [FREQ_W-1:0]  freq_mem [SYMBOLS];
	logic [LW-1:0]      list_mem [SYMBOLS];   // {weight, occupied, leaf}
	logic [YW-1:0]      sym_mem  [SYMBOLS];   // {present, group, depth}
	logic [CODE_W-1:0]  code_mem [SYMBOLS];
	logic [DEPTH_W-1:0] len_mem  [SYMBOLS];

	logic [FREQ_W-1:0]  freq_rd_q;
	logic [LW-1:0]      list_rd_q;
	logic [YW-1:0]      sym_rd_q;
	logic [CODE_W-1:0]  code_rd_q;
	logic [DEPTH_W-1:0] lenrd_q;

	// control registers
	logic [SW-1:0]      s_q;
	logic [CW-1:0]      n_q, i_q, j_q, k_q;
	logic               found_q, over_q, first_q, rd_range_q, rsp_valid_q;
	logic [DEPTH_W-1:0] len_q;

	// payload registers
	logic [SW-1:0]       a_q, b_q;
	logic [WEIGHT_W-1:0] wi_q;
	logic [WEIGHT_W:0]   best_q;
	logic [WORK_W-1:0]   work_q;
	logic [CODE_W-1:0]   code_q;
	logic [LEN_W-1:0]    length_q;
	logic [1:0]          status_q;

	// input decode
	logic [XW-1:0] sym_ext;
	logic          in_range;
	logic [SW-1:0] sym_idx;

	assign sym_ext  = XW'(symbol);
	assign in_range = sym_ext < XW'(SYMBOLS);
	assign sym_idx  = sym_ext[SW-1:0];

	logic                last, fr_present;
	logic [SW-1:0]       s_nxt;
	logic [WEIGHT_W-1:0] list_w;
	logic                list_occ, list_leaf;
	logic                y_present;
	logic [SW-1:0]       y_group;
	logic [DEPTH_W-1:0]  y_depth, dep_inc, d_eff, len_new;
	logic [WEIGHT_W:0]   sum;
	logic                better, match;
	logic [WEIGHT_W-1:0] wsat;
	logic [DEPTH_W-1:0]  len_m1;
	logic [CODE_W-1:0]   v64, code_val;
	logic [LEN_W-1:0]    sh;
	logic                out_free, rsp_load;

	assign last       = s_q == SW'(SYMBOLS - 1);
	assign s_nxt      = last ? '0 : s_q + 1'b1;
	assign fr_present = freq_rd_q != '0;
	assign list_w     = list_rd_q[LW-1:2];
	assign list_occ   = list_rd_q[1];
	assign list_leaf  = list_rd_q[0];
	assign y_present  = sym_rd_q[YW-1];
	assign y_group    = sym_rd_q[DEPTH_W +: SW];
	assign y_depth    = sym_rd_q[DEPTH_W-1:0];
	assign dep_inc    = (y_depth == '1) ? y_depth : y_depth + 1'b1;
	assign d_eff      = (n_q == CW'(1)) ? DEPTH_W'(1) : y_depth;
	assign len_new    = (len_q < d_eff) ? d_eff : len_q;
	assign sum        = {1'b0, wi_q} + {1'b0, list_w};
	assign better     = !found_q || (sum < best_q);
	assign match      = y_present && (y_group == a_q || y_group == b_q);
	assign wsat       = best_q[WEIGHT_W] ? '1 : best_q[WEIGHT_W-1:0];
	assign len_m1     = len_q - 1'b1;

	// first code bit sits at work_q[0]; bits at or past len_q are always zero
	always_comb begin
		for (int k = 0; k < CODE_W; k++) v64[CODE_W-1-k] = work_q[k];
	end
	assign sh       = LEN_W'(CODE_W) - LEN_W'(len_new);
	assign code_val = v64 >> sh;

	// memory write controls
	logic                freq_we, list_we, sym_we, len_we;
	logic [SW-1:0]       freq_wa, list_wa, list_ra;
	logic [FREQ_W-1:0]   freq_wd;
	logic [LW-1:0]       list_wd;
	logic [YW-1:0]       sym_wd;
	logic [DEPTH_W-1:0]  len_wd;

	always_comb begin
		freq_we = (op == OP_CLR) ||
			(op == OP_ACCEPT && command == CMD_WRITE && in_range);
		freq_wa = (op == OP_CLR) ? s_q : sym_idx;
		freq_wd = (op == OP_CLR) ? '0 : frequency;

		list_we = 1'b0;
		list_wa = n_q[SW-1:0];
		list_wd = {WEIGHT_W'(freq_rd_q), 2'b11};
		case (op)
			OP_LD_WR: list_we = fr_present;
			OP_MG_A: begin
				list_we = 1'b1;
				list_wa = a_q;
				list_wd = {wsat, 2'b10};
			end
			OP_MG_B: begin
				list_we = 1'b1;
				list_wa = b_q;
				list_wd = '0;
			end
			default: list_we = 1'b0;
		endcase
		list_ra = (op == OP_FJ_RD) ? j_q[SW-1:0] : i_q[SW-1:0];

		sym_we = (op == OP_LD_WR) || (op == OP_MS_WR && match);
		sym_wd = (op == OP_LD_WR) ? {fr_present, n_q[SW-1:0], DEPTH_W'(0)}
			: {1'b1, a_q, dep_inc};

		len_we = (op == OP_CLR) || (op == OP_LD_WR) || (op == OP_PAD);
		len_wd = (op == OP_PAD) ? len_new : '0;
	end

	always_ff @(posedge clk) begin
		if (freq_we) freq_mem[freq_wa] <= freq_wd;
		freq_rd_q <= freq_mem[s_q];
		if (list_we) list_mem[list_wa] <= list_wd;
		list_rd_q <= list_mem[list_ra];
		if (sym_we) sym_mem[s_q] <= sym_wd;
		sym_rd_q <= sym_mem[s_q];
		if (len_we) len_mem[s_q] <= len_wd;
		if (op == OP_PAD) code_mem[s_q] <= code_val;
		if (op == OP_ACCEPT) begin
			code_rd_q <= code_mem[sym_idx];
			lenrd_q   <= len_mem[sym_idx];
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = (op == OP_ACCEPT && command != CMD_BUILD && command != CMD_READ)
		|| (op == OP_RD_RSP) || (op == OP_DONE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q         <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			found_q     <= 1'b0;
			over_q      <= 1'b0;
			first_q     <= 1'b0;
			rd_range_q  <= 1'b0;
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (op)
				OP_CLR: s_q <= s_nxt;
				OP_ACCEPT: begin
					rd_range_q <= in_range;
					if (command == CMD_BUILD) begin
						s_q    <= '0;
						n_q    <= '0;
						k_q    <= CW'(1);
						over_q <= 1'b0;
					end
				end
				OP_LD_WR: begin
					s_q <= s_nxt;
					if (fr_present) n_q <= n_q + 1'b1;
				end
				OP_FP_INIT: begin
					i_q     <= '0;
					found_q <= 1'b0;
				end
				OP_FI_CHK: begin
					if (list_occ) j_q <= i_q + 1'b1;
					else i_q <= i_q + 1'b1;
				end
				OP_FJ_RD: if (j_q >= n_q) i_q <= i_q + 1'b1;
				OP_FJ_CHK: begin
					if (list_occ && better) found_q <= 1'b1;
					if (list_occ && list_leaf) i_q <= i_q + 1'b1;
					else j_q <= j_q + 1'b1;
				end
				OP_MG_B: s_q <= '0;
				OP_MS_WR: begin
					s_q <= s_nxt;
					if (last) k_q <= k_q + 1'b1;
				end
				OP_AS_INIT: begin
					s_q     <= '0;
					first_q <= 1'b1;
					len_q   <= '0;
				end
				OP_AS_CHK: begin
					if (!y_present || d_eff == '0) s_q <= s_nxt;
					else if (first_q) first_q <= 1'b0;
				end
				OP_STRIP: if (len_q != '0 && work_q[len_m1]) len_q <= len_m1;
				OP_PAD: begin
					len_q <= len_new;
					s_q   <= s_nxt;
					if (len_new > DEPTH_W'(MAX_CODE_LEN)) over_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			OP_FI_CHK: if (list_occ) wi_q <= list_w;
			OP_FJ_CHK: begin
				if (list_occ && better) begin
					best_q <= sum;
					a_q    <= i_q[SW-1:0];
					b_q    <= j_q[SW-1:0];
				end
			end
			OP_AS_INIT: work_q <= '0;
			OP_STRIP: begin
				// drop a trailing one, or set the last bit once none is left
				if (len_q != '0) work_q[len_m1] <= !work_q[len_m1];
			end
			default: ;
		endcase
		if (op == OP_ACCEPT) begin
			code_q   <= '0;
			length_q <= '0;
			status_q <= STS_OK;
		end else if (op == OP_RD_RSP) begin
			code_q   <= '0;
			length_q <= '0;
			status_q <= STS_OK;
			if (!rd_range_q || lenrd_q == '0) begin
				status_q <= STS_ABSENT;
			end else if (lenrd_q > DEPTH_W'(MAX_CODE_LEN)) begin
				length_q <= LEN_W'(MAX_CODE_LEN);
				status_q <= STS_OVERLONG;
			end else begin
				code_q   <= code_rd_q;
				length_q <= LEN_W'(lenrd_q);
			end
		end else if (op == OP_DONE) begin
			code_q   <= '0;
			length_q <= '0;
			if (n_q == '0) status_q <= STS_ABSENT;
			else if (over_q) status_q <= STS_OVERLONG;
			else status_q <= STS_OK;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign code_bits   = code_q;
	assign code_length = length_q;
	assign status      = status_q;

	always_comb begin
		sts.out_free   = out_free;
		sts.last       = last;
		sts.n_zero     = n_q == '0;
		sts.n_one      = n_q == CW'(1);
		sts.i_end      = (i_q + 1'b1) >= n_q;
		sts.j_end      = j_q >= n_q;
		sts.occ        = list_occ;
		sts.leaf       = list_leaf;
		sts.found      = found_q;
		sts.more       = (k_q + 1'b1) < n_q;
		sts.skip       = !y_present || d_eff == '0;
		sts.first      = first_q;
		sts.strip_more = len_q != '0 && work_q[len_m1];
	end

endmodule
`default_nettype wire

/* sv/hu_tucker_code_builder.sv */
// Write and unused words: one per cycle unless rsp_stall holds a response;
//   response in the next cycle. Read word: answered from the registered code
//   memory read. Build word: a load pass, up to n-1 pair search and merge
//   rounds, then assignment with strip steps, n = present symbols. Reset:
//   async, active low; a clearing pass over all SYMBOLS entries zeroes the
//   frequency and code length memories before the first word is taken.
`default_nettype none
// ----------------------------------------------------------------------------
// hu_tucker_code_builder: alphabetic prefix code builder, top level
// Takes write/build/read words and returns one response word per command.
// ----------------------------------------------------------------------------
module hu_tucker_code_builder #(
	parameter int SYMBOLS      = htcb_pkg::SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = htcb_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic [1:0]                  command,
	input  logic [htcb_pkg::SYM_W-1:0]  symbol,
	input  logic [htcb_pkg::FREQ_W-1:0] frequency,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [htcb_pkg::CODE_W-1:0] code_bits,
	output logic [htcb_pkg::LEN_W-1:0]  code_length,
	output logic [1:0]                  status
);
	import htcb_pkg::*;

	dp_op_t  op;
	dp_sts_t sts;

	htcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (command),
		.sts       (sts),
		.op        (op),
		.cmd_stall (cmd_stall)
	);

	htcb_dp #(
		.SYMBOLS      (SYMBOLS),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.command     (command),
		.symbol      (symbol),
		.frequency   (frequency),
		.rsp_stall   (rsp_stall),
		.sts         (sts),
		.rsp_valid   (rsp_valid),
		.code_bits   (code_bits),
		.code_length (code_length),
		.status      (status)
	);

endmodule
`default_nettype wire

/* sv/htcb_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htcb_checker: port-level checks for the alphabetic code builder
// Response word consistency and write turnaround.
// ----------------------------------------------------------------------------
module htcb_checker #(
	parameter int MAX_CODE_LEN = htcb_pkg::MAX_CODE_LEN_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_stall,
	input logic [1:0]                  command,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic [htcb_pkg::CODE_W-1:0] code_bits,
	input logic [htcb_pkg::LEN_W-1:0]  code_length,
	input logic [1:0]                  status
);
	import htcb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(code_bits)
			&& $stable(code_length) && $stable(status))
		else $error("stalled response word changed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> code_length <= LEN_W'(MAX_CODE_LEN))
		else $error("code length above maximum");

	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STS_ABSENT |-> code_length == '0 && code_bits == '0)
		else $error("absent response carries a code");

	// a build word flags overlong with length zero, a read word with the maximum
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STS_OVERLONG |-> code_bits == '0 &&
			(code_length == LEN_W'(MAX_CODE_LEN) || code_length == '0))
		else $error("overlong response malformed");

	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && command == CMD_WRITE |=>
			rsp_valid && status == STS_OK && code_length == '0 && code_bits == '0)
		else $error("write word not answered next cycle");

endmodule

bind hu_tucker_code_builder htcb_checker #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_stall   (cmd_stall),
	.command     (command),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.code_bits   (code_bits),
	.code_length (code_length),
	.status      (status)
);
`default_nettype wire

/* dv/hu_tucker_code_builder_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hu_tucker_code_builder_tb: self-checking bench for the alphabetic code builder
// A directed table, then random write/build/read sequences with small symbol
// sets. Every response word is compared against a fixed table value or an in-bench code predictor.
// ----------------------------------------------------------------------------
module hu_tucker_code_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import htcb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NSYM = 256;
	localparam int MAXLEN = 64;
	localparam logic [39:0] WSAT = 40'hFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 400000;

	typedef struct packed {
		logic [63:0] bits;
		logic [6:0]  len;
		logic [1:0]  sts;
	} rsp_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  sym;
		logic [31:0] freq;
		bit          fixed;
		rsp_t        want;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic cmd_valid = 0, cmd_stall, rsp_valid, rsp_stall = 0;
	logic [1:0] command = '0, status;
	logic [7:0] symbol = '0;
	logic [31:0] frequency = '0;
	logic [63:0] code_bits;
	logic [6:0] code_length;

	hu_tucker_code_builder DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.command(command), .symbol(symbol), .frequency(frequency),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.code_bits(code_bits), .code_length(code_length), .status(status)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// predictor state
	logic [31:0] freq_tab[NSYM];
	logic [39:0] grp_weight[NSYM];
	bit          grp_live[NSYM], grp_leaf[NSYM];
	int          sym_grp[NSYM], sym_depth[NSYM], code_len[NSYM];
	logic [63:0] code_tab[NSYM];
	bit          work[257];

	rsp_t pending_rsp[$];
	int   err_cnt = 0;
	bit   idle_en = 1;
	int   words_sent = 0;

	function automatic void merge_groups(int a, int b);
		logic [63:0] sum;
		sum = 64'(grp_weight[a]) + 64'(grp_weight[b]);
		grp_weight[a] = (sum > 64'(WSAT)) ? WSAT : sum[39:0];
		grp_leaf[a] = 0;
		grp_live[b] = 0;
		for (int s = 0; s < NSYM; s++) begin
			if (freq_tab[s] != 0 && (sym_grp[s] == a || sym_grp[s] == b)) begin
				if (sym_depth[s] < 255) sym_depth[s]++;
				sym_grp[s] = a;
			end
		end
	endfunction

	function automatic bit cheapest_pair(int n, output int pa, output int pb);
		bit found;
		logic [63:0] best, sum;
		found = 0;
		best = 0;
		pa = 0;
		pb = 0;
		for (int i = 0; i + 1 < n; i++) begin
			if (!grp_live[i]) continue;
			for (int j = i + 1; j < n; j++) begin
				if (!grp_live[j]) continue;
				sum = 64'(grp_weight[i]) + 64'(grp_weight[j]);
				if (!found || sum < best) begin
					found = 1;
					best = sum;
					pa = i;
					pb = j;
				end
				if (grp_leaf[j]) break;
			end
		end
		return found;
	endfunction

	function automatic logic [1:0] build_codes();
		int n, len, a, b, d;
		bit first, overlong;
		logic [63:0] v;
		n = 0;
		len = 0;
		first = 1;
		overlong = 0;
		for (int s = 0; s < NSYM; s++) begin
			grp_weight[s] = 0; grp_live[s] = 0; grp_leaf[s] = 0;
			sym_grp[s] = 0; sym_depth[s] = 0; code_tab[s] = 0; code_len[s] = 0;
		end
		for (int s = 0; s < NSYM; s++) begin
			if (freq_tab[s] == 0) continue;
			grp_weight[n] = 40'(freq_tab[s]);
			grp_live[n] = 1;
			grp_leaf[n] = 1;
			sym_grp[s] = n;
			n++;
		end
		if (n == 0) return STS_ABSENT;
		if (n == 1) begin
			for (int s = 0; s < NSYM; s++)
				if (freq_tab[s] != 0) begin
					sym_depth[s] = 1;
					code_len[s] = 1;
				end
			return STS_OK;
		end
		for (int k = 1; k < n; k++) begin
			if (!cheapest_pair(n, a, b)) break;
			merge_groups(a, b);
		end
		for (int s = 0; s < NSYM; s++) begin
			d = sym_depth[s];
			if (freq_tab[s] == 0 || d == 0) continue;
			if (first) begin
				first = 0;
				len = 0;
			end else begin
				while (len > 0 && work[len-1]) len--;
				if (len > 0) work[len-1] = 1;
			end
			while (len < d && len <= 255) work[len++] = 0;
			code_len[s] = len;
			if (len > MAXLEN) overlong = 1;
			else begin
				v = 0;
				for (int k = 0; k < len; k++) v = (v << 1) | 64'(work[k]);
				code_tab[s] = v;
			end
		end
		return overlong ? STS_OVERLONG : STS_OK;
	endfunction

	function automatic rsp_t predict_rsp(logic [1:0] c, logic [7:0] s, logic [31:0] f);
		rsp_t r;
		r = '0;
		case (c)
			CMD_WRITE: freq_tab[s] = f;
			CMD_BUILD: r.sts = build_codes();
			CMD_READ: begin
				if (code_len[s] == 0) r.sts = STS_ABSENT;
				else if (code_len[s] > MAXLEN) begin
					r.len = 7'(MAXLEN);
					r.sts = STS_OVERLONG;
				end else begin
					r.bits = code_tab[s];
					r.len = 7'(code_len[s]);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_word(logic [1:0] c, logic [7:0] s, logic [31:0] f,
			bit fixed = 0, rsp_t want = '0);
		rsp_t r;
		if (idle_en)
			while ($urandom_range(0, 99) < 27) begin
				cmd_valid <= 0;
				@(posedge clk);
			end
		cmd_valid <= 1;
		command <= c;
		symbol <= s;
		frequency <= f;
		do @(posedge clk); while (cmd_stall);
		r = predict_rsp(c, s, f);
		pending_rsp.push_back(fixed ? want : r);
		words_sent++;
	endtask

	task automatic drain();
		cmd_valid <= 0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_freq();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(1) << $urandom_range(0, 31);
			default: return $urandom_range(1, 20);
		endcase
	endfunction

	// response checker and stall generator
	always @(posedge clk) begin
		rsp_t got, want;
		if (rsp_valid && !rsp_stall) begin
			got = '{code_bits, code_length, status};
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) $display("unexpected response word: %p", got);
			end else begin
				want = pending_rsp.pop_front();
				if (got !== want) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp bits=%h len=%0d sts=%0d got bits=%h len=%0d sts=%0d",
							want.bits, want.len, want.sts, got.bits, got.len, got.sts);
				end
			end
		end
		rsp_stall <= idle_en && ($urandom_range(0, 99) < 27);
	end

	// watchdog on cycles without any accepted word
	int quiet = 0;
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	row_t dir_tab[] = '{
		'{CMD_READ,   8'd0,   32'd0,          1, '{64'd0, 7'd0, STS_ABSENT}},
		'{CMD_BUILD,  8'd0,   32'd0,          1, '{64'd0, 7'd0, STS_ABSENT}},
		'{CMD_UNUSED, 8'hA5,  32'hFFFF_FFFF,  1, '{64'd0, 7'd0, STS_OK}},
		'{CMD_WRITE,  8'd255, 32'hFFFF_FFFF,  1, '{64'd0, 7'd0, STS_OK}},
		'{CMD_BUILD,  8'd0,   32'd0,          1, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd255, 32'd0,          1, '{64'd0, 7'd1, STS_OK}},
		'{CMD_READ,   8'd0,   32'd0,          1, '{64'd0, 7'd0, STS_ABSENT}},
		'{CMD_WRITE,  8'd0,   32'd1,          1, '{64'd0, 7'd0, STS_OK}},
		'{CMD_WRITE,  8'd128, 32'h8000_0000,  1, '{64'd0, 7'd0, STS_OK}},
		'{CMD_WRITE,  8'd64,  32'd1,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_BUILD,  8'd0,   32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd0,   32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd64,  32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd128, 32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd255, 32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		// later writes leave the built codes alone
		'{CMD_WRITE,  8'd255, 32'd0,          1, '{64'd0, 7'd0, STS_OK}},
		'{CMD_WRITE,  8'd7,   32'd5,          1, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd255, 32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd7,   32'd0,          1, '{64'd0, 7'd0, STS_ABSENT}},
		'{CMD_BUILD,  8'd0,   32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd7,   32'd0,          0, '{64'd0, 7'd0, STS_OK}},
		'{CMD_READ,   8'd255, 32'd0,          1, '{64'd0, 7'd0, STS_ABSENT}},
		'{CMD_UNUSED, 8'h5A,  32'd0,          1, '{64'd0, 7'd0, STS_OK}}
	};

	initial begin
		int k, seq;
		for (int s = 0; s < NSYM; s++) begin
			freq_tab[s] = 0; code_len[s] = 0; code_tab[s] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].cmd, dir_tab[i].sym, dir_tab[i].freq,
				dir_tab[i].fixed, dir_tab[i].want);

		seq = 0;
		while (words_sent < 1800) begin
			seq++;
			idle_en = !(seq >= 25 && seq < 40);
			if (seq == 12) drain();
			// clear most of the previous symbol set so builds stay short
			for (int s = 0; s < NSYM; s++)
				if (freq_tab[s] != 0 && $urandom_range(0, 9) != 0)
					send_word(CMD_WRITE, 8'(s), 32'd0);
			k = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 12);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(2'($urandom_range(0, 3)), 8'($urandom), $urandom);
				send_word(CMD_WRITE, 8'($urandom), rand_freq());
			end
			send_word(CMD_BUILD, 8'($urandom), $urandom);
			for (int i = 0; i < k + 3; i++)
				send_word(CMD_READ, 8'($urandom), $urandom);
			for (int s = 0; s < NSYM; s++)
				if (freq_tab[s] != 0 && $urandom_range(0, 1))
					send_word(CMD_READ, 8'(s), $urandom);
		end

		drain();
		repeat (50) @(posedge clk);
		if (err_cnt == 0 && pending_rsp.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
